@@ rtl/metric_statistics_table_macros.svh @@
// Assertion macros shared by the statistics table RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef METRIC_STATISTICS_TABLE_MACROS_SVH
`define METRIC_STATISTICS_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("statistics table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("statistics table assertion failed");

`endif

@@ rtl/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// Statistics table package
// Field widths, operation and status codes, slot layout and the control
// structures shared by the statistics table modules.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int DEF_MAX_SLOTS = 256;

    localparam int OPCODE_W     = 3;
    localparam int SLOT_INDEX_W = 8;
    localparam int KIND_W       = 2;
    localparam int DATA_W       = 64;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 9;

    localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_REGISTER = 3'd0,
        OP_FINALIZE = 3'd1,
        OP_ADD      = 3'd2,
        OP_SET      = 3'd3,
        OP_RECORD   = 3'd4,
        OP_READ     = 3'd5,
        OP_CLEAR    = 3'd6,
        OP_SIZE     = 3'd7
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE      = 2'd0,
        KIND_COUNTER   = 2'd1,
        KIND_GAUGE     = 2'd2,
        KIND_HISTOGRAM = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_FINALIZED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] min;
        logic [DATA_W-1:0] max;
    } t_slot;

    typedef struct packed {
        t_opcode                 opcode;
        logic [SLOT_INDEX_W-1:0] slot_index;
        t_kind                   metric_kind;
        logic [DATA_W-1:0]       operand_value;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_INDEX_W-1:0] assigned_index;
        logic [TOTAL_W-1:0]      registered_total;
        t_kind                   slot_kind;
        logic [DATA_W-1:0]       slot_value;
        logic [DATA_W-1:0]       slot_sum;
        logic [DATA_W-1:0]       slot_count;
        logic [DATA_W-1:0]       slot_min;
        logic [DATA_W-1:0]       slot_max;
    } t_result;

    typedef struct packed {
        logic mem_we;
        logic reg_inc;
        logic set_final;
    } t_exec_ctl;

endpackage

@@ rtl/mst_if.sv @@
// ----------------------------------------------------------------------------
// Statistics table channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface mst_in_if import mst_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [KIND_W-1:0]       metric_kind;
    logic [DATA_W-1:0]       operand_value;

    modport source (
        output valid, opcode, slot_index, metric_kind, operand_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, metric_kind, operand_value,
        output ready
    );
endinterface

interface mst_out_if import mst_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] assigned_index;
    logic [TOTAL_W-1:0]      registered_total;
    logic [KIND_W-1:0]       slot_kind;
    logic [DATA_W-1:0]       slot_value;
    logic [DATA_W-1:0]       slot_sum;
    logic [DATA_W-1:0]       slot_count;
    logic [DATA_W-1:0]       slot_min;
    logic [DATA_W-1:0]       slot_max;

    modport source (
        output valid, status, assigned_index, registered_total, slot_kind,
               slot_value, slot_sum, slot_count, slot_min, slot_max,
        input  ready
    );
    modport sink (
        input  valid, status, assigned_index, registered_total, slot_kind,
               slot_value, slot_sum, slot_count, slot_min, slot_max,
        output ready
    );
endinterface

@@ rtl/mst_exec.sv @@
// ----------------------------------------------------------------------------
// Statistics table execute stage
// Decodes one operation against the slot read from the table and produces
// the write-back entry, the control updates and the result item.
// ----------------------------------------------------------------------------
module mst_exec import mst_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    localparam int AW = $clog2(MAX_SLOTS),
    localparam int RW = $clog2(MAX_SLOTS + 1)
) (
    input  t_cmd            i_cmd,
    input  t_slot           i_rd_slot,
    input  logic [RW-1:0]   i_reg_count,
    input  logic            i_finalized,
    output t_exec_ctl       o_ctl,
    output logic [AW-1:0]   o_wr_addr,
    output t_slot           o_wr_slot,
    output t_result         o_result
);

    localparam int CW  = (AW > SLOT_INDEX_W) ? AW : SLOT_INDEX_W;
    localparam int CXW = CW + 1;
    localparam int XW  = (RW > TOTAL_W) ? RW : TOTAL_W;

    logic [CXW-1:0] idx_ext;
    logic [XW-1:0]  cnt_ext;
    logic           registered;
    logic           full;
    logic [AW-1:0]  idx_addr;

    assign idx_ext    = CXW'(i_cmd.slot_index);
    assign cnt_ext    = XW'(i_reg_count);
    assign registered = idx_ext < CXW'(i_reg_count);
    assign full       = i_reg_count >= RW'(MAX_SLOTS);
    assign idx_addr   = idx_ext[AW-1:0];

    always_comb begin
        o_ctl     = '0;
        o_wr_addr = idx_addr;
        o_wr_slot = i_rd_slot;
        o_result  = '0;
        o_result.status = ST_DONE;
        case (i_cmd.opcode)
            OP_REGISTER: begin
                if (i_finalized) begin
                    o_result.status = ST_FINALIZED;
                end else if (i_cmd.metric_kind == KIND_NONE) begin
                    o_result.status = ST_IGNORED;
                end else if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_ctl.mem_we    = 1'b1;
                    o_ctl.reg_inc   = 1'b1;
                    o_wr_addr       = i_reg_count[AW-1:0];
                    o_wr_slot.kind  = i_cmd.metric_kind;
                    o_wr_slot.value = '0;
                    o_wr_slot.sum   = '0;
                    o_wr_slot.count = '0;
                    o_wr_slot.min   = DATA_ONES;
                    o_wr_slot.max   = '0;
                    o_result.assigned_index = cnt_ext[SLOT_INDEX_W-1:0];
                end
            end
            OP_FINALIZE: begin
                o_ctl.set_final = 1'b1;
            end
            OP_ADD: begin
                if (registered && i_rd_slot.kind == KIND_COUNTER) begin
                    o_ctl.mem_we    = 1'b1;
                    o_wr_slot.value = i_rd_slot.value + i_cmd.operand_value;
                end else begin
                    o_result.status = ST_IGNORED;
                end
            end
            OP_SET: begin
                if (registered && i_rd_slot.kind == KIND_GAUGE) begin
                    o_ctl.mem_we    = 1'b1;
                    o_wr_slot.value = i_cmd.operand_value;
                end else begin
                    o_result.status = ST_IGNORED;
                end
            end
            OP_RECORD: begin
                if (registered && i_rd_slot.kind == KIND_HISTOGRAM) begin
                    o_ctl.mem_we    = 1'b1;
                    o_wr_slot.count = i_rd_slot.count + DATA_W'(1);
                    o_wr_slot.sum   = i_rd_slot.sum + i_cmd.operand_value;
                    if (i_cmd.operand_value < i_rd_slot.min) begin
                        o_wr_slot.min = i_cmd.operand_value;
                    end
                    if (i_cmd.operand_value > i_rd_slot.max) begin
                        o_wr_slot.max = i_cmd.operand_value;
                    end
                end else begin
                    o_result.status = ST_IGNORED;
                end
            end
            OP_READ: begin
                if (registered) begin
                    o_result.slot_kind  = i_rd_slot.kind;
                    o_result.slot_value = i_rd_slot.value;
                    o_result.slot_sum   = i_rd_slot.sum;
                    o_result.slot_count = i_rd_slot.count;
                    o_result.slot_min   = i_rd_slot.min;
                    o_result.slot_max   = i_rd_slot.max;
                end else begin
                    o_result.status = ST_IGNORED;
                end
            end
            OP_CLEAR: begin
                o_result.status = ST_DONE;
            end
            OP_SIZE: begin
                o_result.registered_total = cnt_ext[TOTAL_W-1:0];
            end
            default: begin
                o_result.status = ST_DONE;
            end
        endcase
    end

endmodule

@@ rtl/metric_statistics_table.sv @@
// ----------------------------------------------------------------------------
// Metric statistics table
// A table of counter, gauge and histogram slots held in one synchronous
// memory, updated by read, modify and write-back of one slot per non-clear operation.
//
// Channel    Direction  Handshake     Contents
// i_item     in         valid/ready   opcode, slot_index, metric_kind, operand_value
// o_result   out        valid/ready   status, index, total, kind and slot fields
//
// An item's slot is read from the table in the cycle the item is accepted and its
// result is registered from the execute state; no new item is accepted until idle.
// Clear histograms sweeps the registered slots and resets each histogram slot.
// Reset is synchronous and needs no clearing pass: the registration count marks
// the written entries, and a slot is initialised when it is registered.
// A waiting result is held in the output register; the next item is accepted in
// the cycle that result is taken.
// ----------------------------------------------------------------------------
`include "metric_statistics_table_macros.svh"

module metric_statistics_table import mst_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mst_in_if.sink    i_item,
    mst_out_if.source o_result
);

    localparam int AW  = $clog2(MAX_SLOTS);
    localparam int RW  = $clog2(MAX_SLOTS + 1);
    localparam int CW  = (AW > SLOT_INDEX_W) ? AW : SLOT_INDEX_W;

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [RW-1:0] r_reg_count;
    logic          r_finalized;
    logic [AW-1:0] r_sweep, n_sweep;
    logic          r_out_valid;
    t_result       r_out;
    t_slot         r_rd_slot;
    t_slot         r_mem [MAX_SLOTS];

    t_cmd          in_cmd;
    logic [CW-1:0] in_idx_ext;
    logic          in_ready;
    logic          accept;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    t_slot         wr_slot;
    logic          load_out;
    logic          sweep_hit;
    logic          sweep_last;

    t_exec_ctl     exec_ctl;
    logic [AW-1:0] exec_wr_addr;
    t_slot         exec_wr_slot;
    t_result       exec_result;

    assign in_cmd.opcode        = t_opcode'(i_item.opcode);
    assign in_cmd.slot_index    = i_item.slot_index;
    assign in_cmd.metric_kind   = t_kind'(i_item.metric_kind);
    assign in_cmd.operand_value = i_item.operand_value;
    assign in_idx_ext           = CW'(i_item.slot_index);

    assign in_ready     = (r_state == S_IDLE) && (!r_out_valid || o_result.ready);
    assign accept       = i_item.valid && in_ready;
    assign i_item.ready = in_ready;

    assign sweep_hit  = (RW'(r_sweep) < r_reg_count) && (r_rd_slot.kind == KIND_HISTOGRAM);
    assign sweep_last = (RW'(r_sweep) + RW'(1)) >= r_reg_count;

    mst_exec #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_exec (
        .i_cmd       (r_cmd),
        .i_rd_slot   (r_rd_slot),
        .i_reg_count (r_reg_count),
        .i_finalized (r_finalized),
        .o_ctl       (exec_ctl),
        .o_wr_addr   (exec_wr_addr),
        .o_wr_slot   (exec_wr_slot),
        .o_result    (exec_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_cmd.opcode == OP_CLEAR) ? S_CLEAR : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_addr  = '0;
        mem_we   = 1'b0;
        wr_addr  = exec_wr_addr;
        wr_slot  = exec_wr_slot;
        load_out = 1'b0;
        n_sweep  = r_sweep;
        case (r_state)
            S_IDLE: begin
                rd_addr = (in_cmd.opcode == OP_CLEAR) ? '0 : in_idx_ext[AW-1:0];
                n_sweep = '0;
            end
            S_EXEC: begin
                mem_we   = exec_ctl.mem_we;
                load_out = 1'b1;
            end
            S_CLEAR: begin
                rd_addr       = r_sweep + AW'(1);
                n_sweep       = r_sweep + AW'(1);
                mem_we        = sweep_hit;
                wr_addr       = r_sweep;
                wr_slot       = r_rd_slot;
                wr_slot.sum   = '0;
                wr_slot.count = '0;
                wr_slot.min   = DATA_ONES;
                wr_slot.max   = '0;
                load_out      = sweep_last;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reg_count <= '0;
            r_finalized <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweep     <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            if (r_state == S_EXEC && exec_ctl.reg_inc) begin
                r_reg_count <= r_reg_count + RW'(1);
            end
            if (r_state == S_EXEC && exec_ctl.set_final) begin
                r_finalized <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= in_cmd;
        end
        if (load_out) begin
            r_out <= exec_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_slot;
        end
        r_rd_slot <= r_mem[rd_addr];
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.status           = r_out.status;
    assign o_result.assigned_index   = r_out.assigned_index;
    assign o_result.registered_total = r_out.registered_total;
    assign o_result.slot_kind        = r_out.slot_kind;
    assign o_result.slot_value       = r_out.slot_value;
    assign o_result.slot_sum         = r_out.slot_sum;
    assign o_result.slot_count       = r_out.slot_count;
    assign o_result.slot_min         = r_out.slot_min;
    assign o_result.slot_max         = r_out.slot_max;

    `MST_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, accept && in_cmd.opcode != OP_CLEAR, r_state == S_EXEC)
    `MST_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, r_state == S_EXEC, r_out_valid)
    `MST_ASSERT_SAME(a_busy_output_free, i_clk, i_rst_n, r_state != S_IDLE, !r_out_valid)
    `MST_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n, 1'b1, r_reg_count <= RW'(MAX_SLOTS))

endmodule

@@ tb/sv/tb_metric_statistics_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metric statistics table testbench
// Sends operation items through the input channel and checks every result item
// against a predictor that keeps its own copy of the slot table. A directed
// opening covers the field extremes, every operation but finalize, and the
// ignored cases. Random phases with different idle and stall rates follow.
// They fill the table, close registration and then work on the closed table.
// ----------------------------------------------------------------------------
module tb_metric_statistics_table;
    import mst_pkg::*;

    localparam int SLOTS = DEF_MAX_SLOTS;
    localparam int TAIL_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    mst_in_if  item_bus ();
    mst_out_if result_bus ();

    metric_statistics_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    t_kind             slot_kinds [SLOTS];
    logic [DATA_W-1:0] slot_values [SLOTS];
    logic [DATA_W-1:0] hist_sums [SLOTS];
    logic [DATA_W-1:0] hist_hits [SLOTS];
    logic [DATA_W-1:0] hist_lows [SLOTS];
    logic [DATA_W-1:0] hist_highs [SLOTS];
    int unsigned       slots_taken;
    bit                table_closed;

    t_kind       plan_kinds [SLOTS];
    int unsigned plan_taken;
    bit          plan_closed;

    t_cmd    pending_items [$];
    t_result table_replies [$];
    t_cmd    next_cmd;
    t_cmd    seen_cmd;
    t_result want;

    int sender_idle_pct;
    int receiver_stall_pct;
    int results_owed = 0;
    int result_number = 0;
    int mismatch_count = 0;
    bit item_taken = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_result step_table(t_cmd c);
        t_result     r;
        int unsigned slot;
        r = '0;
        slot = 32'(c.slot_index);
        case (c.opcode)
            OP_REGISTER: begin
                if (table_closed) begin
                    r.status = ST_FINALIZED;
                end else if (c.metric_kind == KIND_NONE) begin
                    r.status = ST_IGNORED;
                end else if (slots_taken >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    slot_kinds[slots_taken] = c.metric_kind;
                    r.assigned_index = SLOT_INDEX_W'(slots_taken);
                    slots_taken++;
                end
            end
            OP_FINALIZE: begin
                table_closed = 1'b1;
            end
            OP_ADD: begin
                if (slot_kinds[slot] == KIND_COUNTER) begin
                    slot_values[slot] = slot_values[slot] + c.operand_value;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            OP_SET: begin
                if (slot_kinds[slot] == KIND_GAUGE) begin
                    slot_values[slot] = c.operand_value;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            OP_RECORD: begin
                if (slot_kinds[slot] == KIND_HISTOGRAM) begin
                    hist_hits[slot] = hist_hits[slot] + 1;
                    hist_sums[slot] = hist_sums[slot] + c.operand_value;
                    if (c.operand_value < hist_lows[slot]) begin
                        hist_lows[slot] = c.operand_value;
                    end
                    if (c.operand_value > hist_highs[slot]) begin
                        hist_highs[slot] = c.operand_value;
                    end
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            OP_READ: begin
                if (slot < slots_taken) begin
                    r.slot_kind  = slot_kinds[slot];
                    r.slot_value = slot_values[slot];
                    r.slot_sum   = hist_sums[slot];
                    r.slot_count = hist_hits[slot];
                    r.slot_min   = hist_lows[slot];
                    r.slot_max   = hist_highs[slot];
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < slots_taken; i++) begin
                    if (slot_kinds[i] == KIND_HISTOGRAM) begin
                        hist_sums[i]  = '0;
                        hist_hits[i]  = '0;
                        hist_lows[i]  = DATA_ONES;
                        hist_highs[i] = '0;
                    end
                end
            end
            OP_SIZE: begin
                r.registered_total = TOTAL_W'(slots_taken);
            end
            default: begin
                r.status = ST_DONE;
            end
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return DATA_ONES;
            2: return DATA_ONES - DATA_W'($urandom_range(15));
            3: return DATA_W'($urandom_range(1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_item(t_opcode op, int unsigned slot, t_kind kind,
                             logic [DATA_W-1:0] val);
        t_cmd c;
        c.opcode        = op;
        c.slot_index    = SLOT_INDEX_W'(slot);
        c.metric_kind   = kind;
        c.operand_value = val;
        if (op == OP_REGISTER && !plan_closed && kind != KIND_NONE && plan_taken < SLOTS) begin
            plan_kinds[plan_taken] = kind;
            plan_taken++;
        end
        if (op == OP_FINALIZE) begin
            plan_closed = 1'b1;
        end
        pending_items.push_back(c);
    endtask

    // Items that address a registered slot mostly use the operation that suits its kind.
    task automatic queue_random(int items, int register_pct, bit allow_close);
        int          roll;
        int unsigned slot;
        t_opcode     op;
        repeat (items) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                op = t_opcode'($urandom_range(7));
                if (op == OP_FINALIZE && !allow_close) begin
                    op = OP_SIZE;
                end
                push_item(op, $urandom_range(255), t_kind'($urandom_range(3)), pick_value());
            end else if (roll < 12 + register_pct || plan_taken == 0) begin
                push_item(OP_REGISTER, $urandom_range(255),
                          ($urandom_range(9) == 0) ? KIND_NONE : t_kind'($urandom_range(1, 3)),
                          pick_value());
            end else if (roll >= 96) begin
                push_item(roll[0] ? OP_CLEAR : OP_SIZE, $urandom_range(255),
                          t_kind'($urandom_range(3)), pick_value());
            end else begin
                slot = $urandom_range(plan_taken - 1);
                if ($urandom_range(4) == 0) begin
                    op = OP_READ;
                end else if (plan_kinds[slot] == KIND_COUNTER) begin
                    op = OP_ADD;
                end else if (plan_kinds[slot] == KIND_GAUGE) begin
                    op = OP_SET;
                end else begin
                    op = OP_RECORD;
                end
                push_item(op, slot, t_kind'($urandom_range(3)), pick_value());
            end
        end
    endtask

    task automatic drain_table();
        while (pending_items.size() != 0 || item_bus.valid || results_owed != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < 100) begin
            $display("MISMATCH: %s", msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp);
        if (got !== exp) begin
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      result_number, name, got, exp));
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid         <= 1'b0;
            item_bus.opcode        <= '0;
            item_bus.slot_index    <= '0;
            item_bus.metric_kind   <= '0;
            item_bus.operand_value <= '0;
            result_bus.ready       <= 1'b0;
        end else begin
            if (!item_bus.valid || item_taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_cmd = pending_items.pop_front();
                    item_bus.valid         <= 1'b1;
                    item_bus.opcode        <= next_cmd.opcode;
                    item_bus.slot_index    <= next_cmd.slot_index;
                    item_bus.metric_kind   <= next_cmd.metric_kind;
                    item_bus.operand_value <= next_cmd.operand_value;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                if (table_replies.size() == 0) begin
                    report_mismatch("result item with no item outstanding");
                end else begin
                    want = table_replies.pop_front();
                    check_field("status", result_bus.status, want.status);
                    check_field("assigned_index", result_bus.assigned_index,
                                want.assigned_index);
                    check_field("registered_total", result_bus.registered_total,
                                want.registered_total);
                    check_field("slot_kind", result_bus.slot_kind, want.slot_kind);
                    check_field("slot_value", result_bus.slot_value, want.slot_value);
                    check_field("slot_sum", result_bus.slot_sum, want.slot_sum);
                    check_field("slot_count", result_bus.slot_count, want.slot_count);
                    check_field("slot_min", result_bus.slot_min, want.slot_min);
                    check_field("slot_max", result_bus.slot_max, want.slot_max);
                end
                result_number++;
            end
            if (item_bus.valid && item_bus.ready) begin
                seen_cmd.opcode        = t_opcode'(item_bus.opcode);
                seen_cmd.slot_index    = item_bus.slot_index;
                seen_cmd.metric_kind   = t_kind'(item_bus.metric_kind);
                seen_cmd.operand_value = item_bus.operand_value;
                table_replies.push_back(step_table(seen_cmd));
            end
            results_owed <= results_owed + int'(item_bus.valid && item_bus.ready)
                            - int'(result_bus.valid && result_bus.ready);
            item_taken <= item_bus.valid && item_bus.ready;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_kinds[i]  = KIND_NONE;
            slot_values[i] = '0;
            hist_sums[i]   = '0;
            hist_hits[i]   = '0;
            hist_lows[i]   = DATA_ONES;
            hist_highs[i]  = '0;
        end
        slots_taken  = 0;
        table_closed = 1'b0;
        plan_taken   = 0;
        plan_closed  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(OP_SIZE, 0, KIND_NONE, '0);
        push_item(OP_READ, 0, KIND_HISTOGRAM, DATA_ONES);
        push_item(OP_REGISTER, 255, KIND_NONE, '0);
        push_item(OP_REGISTER, 0, KIND_COUNTER, '0);
        push_item(OP_REGISTER, 0, KIND_GAUGE, '0);
        push_item(OP_REGISTER, 0, KIND_HISTOGRAM, '0);
        push_item(OP_READ, 2, KIND_NONE, '0);
        push_item(OP_ADD, 0, KIND_NONE, DATA_ONES);
        push_item(OP_ADD, 0, KIND_NONE, 64'd2);
        push_item(OP_SET, 1, KIND_NONE, DATA_ONES);
        push_item(OP_SET, 1, KIND_NONE, '0);
        push_item(OP_RECORD, 2, KIND_NONE, '0);
        push_item(OP_RECORD, 2, KIND_NONE, DATA_ONES);
        push_item(OP_RECORD, 2, KIND_NONE, 64'd5);
        push_item(OP_RECORD, 2, KIND_NONE, 64'h8000_0000_0000_0000);
        push_item(OP_ADD, 1, KIND_COUNTER, 64'd7);
        push_item(OP_SET, 255, KIND_GAUGE, 64'd9);
        push_item(OP_RECORD, 0, KIND_HISTOGRAM, 64'd3);
        push_item(OP_READ, 0, KIND_NONE, '0);
        push_item(OP_READ, 1, KIND_NONE, '0);
        push_item(OP_READ, 2, KIND_NONE, '0);
        push_item(OP_CLEAR, 0, KIND_NONE, '0);
        push_item(OP_READ, 2, KIND_NONE, '0);
        push_item(OP_SIZE, 255, KIND_HISTOGRAM, DATA_ONES);
        push_item(OP_READ, 255, KIND_HISTOGRAM, DATA_ONES);
        queue_random(200, 40, 1'b0);
        drain_table();

        sender_idle_pct = 69;
        queue_random(220, 40, 1'b0);
        drain_table();

        sender_idle_pct    = 0;
        receiver_stall_pct = 69;
        queue_random(220, 40, 1'b0);
        while (plan_taken < SLOTS) begin
            push_item(OP_REGISTER, $urandom_range(255), t_kind'($urandom_range(1, 3)),
                      pick_value());
        end
        push_item(OP_REGISTER, 0, KIND_COUNTER, '0);
        push_item(OP_REGISTER, 0, KIND_NONE, '0);
        push_item(OP_SIZE, 0, KIND_NONE, '0);
        push_item(OP_FINALIZE, 0, KIND_NONE, '0);
        push_item(OP_REGISTER, 0, KIND_GAUGE, '0);
        push_item(OP_REGISTER, 0, KIND_NONE, '0);
        push_item(OP_FINALIZE, 0, KIND_NONE, '0);
        push_item(OP_READ, 255, KIND_NONE, '0);
        drain_table();

        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        queue_random(220, 5, 1'b1);
        drain_table();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_replies.size() != 0) begin
            report_mismatch($sformatf("%0d items left without a result", table_replies.size()));
        end
        if (mismatch_count == 0) begin
            $display("metric_statistics_table test passed");
        end else begin
            $display("metric_statistics_table test failed");
        end
        $finish;
    end

    initial begin
        #(600000 * 12);
        $display("TIMEOUT: the run did not finish in time");
        $display("metric_statistics_table test failed");
        $finish;
    end

endmodule
